// ----- hw/rtl/pmi_pkg.sv -----
// Package for the polarizer mosaic intensity block: field widths, register
// and pattern codes, Q2.14 analyzer coefficients and the coefficient lookup.
// No dependencies.
package pmi_pkg;

  localparam int unsigned CfgW      = 13;
  localparam int unsigned TotalW    = 16;
  localparam int unsigned StokesW   = 17;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned IntensW   = 16;
  localparam int unsigned PhaseW    = 4;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [PhaseW-1:0] PhaseLast = 4'd11;

  localparam logic [CfgW-1:0] ResetWidth  = 13'd640;
  localparam logic [CfgW-1:0] ResetHeight = 13'd480;

  typedef enum logic [CfgIndexW-1:0] {
    REG_PATTERN_MODE = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PAT_2X2A = 2'd0,
    PAT_2X2B = 2'd1,
    PAT_3X2  = 2'd2,
    PAT_4X2  = 2'd3
  } pattern_e;

  // Q2.14: 1, 0.5, sqrt(2)/2, sqrt(3)/2
  localparam logic signed [CoefW-1:0] QOne  = 16'sd16384;
  localparam logic signed [CoefW-1:0] QHalf = 16'sd8192;
  localparam logic signed [CoefW-1:0] QR2   = 16'sd11585;
  localparam logic signed [CoefW-1:0] QR3   = 16'sd14189;
  localparam logic signed [CoefW-1:0] QZero = 16'sd0;

  typedef struct packed {
    logic signed [CoefW-1:0] cos_c;
    logic signed [CoefW-1:0] sin_c;
  } coef_pair_t;

  // Scan position of the pixel at the input
  typedef struct packed {
    logic              row_odd;
    logic [PhaseW-1:0] phase;
    logic              frame_last;
  } scan_pos_t;

  function automatic coef_pair_t pair(logic signed [CoefW-1:0] c,
                                      logic signed [CoefW-1:0] s);
    coef_pair_t r;
    r.cos_c = c;
    r.sin_c = s;
    return r;
  endfunction

  // phase is 0..11
  function automatic logic [1:0] mod3(logic [PhaseW-1:0] v);
    logic [1:0] r;
    unique case (v)
      4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
      default:                 r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic coef_pair_t coef_lookup(pattern_e mode, logic row_odd,
                                             logic [PhaseW-1:0] phase);
    coef_pair_t r;
    logic [1:0] slot3;
    slot3 = mod3(phase);
    r = pair(QZero, QZero);
    unique case (mode)
      PAT_2X2A: begin
        unique case ({row_odd, phase[0]})
          2'b00: r = pair(-QOne, QZero);
          2'b01: r = pair(QZero, -QOne);
          2'b10: r = pair(QZero, QOne);
          2'b11: r = pair(QOne, QZero);
          default: r = pair(QZero, QZero);
        endcase
      end
      PAT_2X2B: begin
        unique case ({row_odd, phase[0]})
          2'b00: r = pair(QR2, QR2);
          2'b01: r = pair(-QR2, QR2);
          2'b10: r = pair(-QR2, -QR2);
          2'b11: r = pair(QR2, -QR2);
          default: r = pair(QZero, QZero);
        endcase
      end
      PAT_3X2: begin
        unique case ({row_odd, slot3})
          3'b000: r = pair(QOne, QZero);
          3'b001: r = pair(-QHalf, -QR3);
          3'b010: r = pair(-QHalf, QR3);
          3'b100: r = pair(-QOne, QZero);
          3'b101: r = pair(QHalf, QR3);
          3'b110: r = pair(QHalf, -QR3);
          default: r = pair(QZero, QZero);
        endcase
      end
      PAT_4X2: begin
        unique case ({row_odd, phase[1:0]})
          3'b000: r = pair(QOne, QZero);
          3'b001: r = pair(QZero, QOne);
          3'b010: r = pair(-QOne, QZero);
          3'b011: r = pair(QZero, -QOne);
          3'b100: r = pair(-QOne, QZero);
          3'b101: r = pair(QZero, -QOne);
          3'b110: r = pair(QOne, QZero);
          3'b111: r = pair(QZero, QOne);
          default: r = pair(QZero, QZero);
        endcase
      end
      default: r = pair(QZero, QZero);
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/pmi_scan.sv -----
// Raster scan counters: column, row and column phase (modulo twelve).
// Depends on pmi_pkg.
module pmi_scan #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic [pmi_pkg::CfgW-1:0] frame_width_i,
  input  logic [pmi_pkg::CfgW-1:0] frame_height_i,
  output pmi_pkg::scan_pos_t       pos_o
);
  import pmi_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW = (DimW > CfgW) ? DimW : CfgW;
  localparam logic [CmpW-1:0] MaxDim = CmpW'(MAX_DIM);

  logic [CntW-1:0]   col_q, col_d;
  logic [CntW-1:0]   row_q, row_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CmpW-1:0]   width_raw, height_raw, width_eff, height_eff;
  logic              row_last, frame_last;

  assign width_raw  = CmpW'(frame_width_i);
  assign height_raw = CmpW'(frame_height_i);

  // Zero acts as one, oversized acts as the maximum
  always_comb begin
    priority if (width_raw == '0) width_eff = CmpW'(1);
    else if (width_raw > MaxDim)  width_eff = MaxDim;
    else                          width_eff = width_raw;
    priority if (height_raw == '0) height_eff = CmpW'(1);
    else if (height_raw > MaxDim)  height_eff = MaxDim;
    else                           height_eff = height_raw;
  end

  assign row_last   = (CmpW'(col_q) + CmpW'(1)) >= width_eff;
  assign frame_last = row_last && ((CmpW'(row_q) + CmpW'(1)) >= height_eff);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    if (advance_i) begin
      if (row_last) begin
        col_d   = '0;
        phase_d = '0;
        row_d   = frame_last ? '0 : row_q + CntW'(1);
      end else begin
        col_d   = col_q + CntW'(1);
        phase_d = (phase_q == PhaseLast) ? '0 : phase_q + PhaseW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  assign pos_o.row_odd    = row_q[0];
  assign pos_o.phase      = phase_q;
  assign pos_o.frame_last = frame_last;

endmodule

// ----- hw/rtl/polarizer_mosaic_intensity.sv -----
// Top level of the polarizer mosaic intensity block: config registers,
// two-stage multiply / round-saturate pipeline. Depends on pmi_pkg, pmi_scan.
//
//   port group     dir  payload
//   s_axis_*       in   tdata: stokes_total, stokes_horiz, stokes_diag
//   m_axis_*       out  tdata: intensity; tlast: frame_end
//   cfg_*          in   cfg_index_i register index, cfg_data_i value
//
// Output valid rises once the pixel has passed the stage-one register and the
// output register; one pixel per clock sustained while m_axis_tready is high.
// Stage one multiplies S1 and S2 by the selected Q2.14 coefficients, stage two
// sums, rounds and saturates into the output register.
// Reset clears valids and scan counters and loads mode 0, 640 x 480.
// A stall on the output stops stage two; the input keeps accepting while
// stage one is empty.
module polarizer_mosaic_intensity #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // [15:0] stokes_total, [32:16] stokes_horiz, [49:33] stokes_diag
  input  logic [pmi_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] intensity
  output logic [pmi_pkg::IntensW-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmi_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pmi_pkg::CfgW-1:0]      cfg_data_i
);
  import pmi_pkg::*;

  localparam int unsigned ProdW = CoefW + StokesW;
  localparam int unsigned AccW  = ProdW + 1;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(16384);

  pattern_e          mode_q;
  logic [CfgW-1:0]   width_q, height_q;

  logic                      v1_q, v1_d;
  logic [TotalW-1:0]         total_q;
  logic signed [ProdW-1:0]   ph_q, ph_d, pd_q, pd_d;
  logic                      last1_q;
  logic                      v2_q;
  logic [IntensW-1:0]        out_q, out_d;
  logic                      last2_q;

  logic                      in_xfer, adv2;
  logic [TotalW-1:0]         s_total;
  logic signed [StokesW-1:0] s_horiz, s_diag;
  scan_pos_t                 pos;
  coef_pair_t                coef;
  logic signed [AccW-1:0]    acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= PAT_2X2A;
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN_MODE: mode_q   <= pattern_e'(cfg_data_i[1:0]);
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign adv2          = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = !v1_q || adv2;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  pmi_scan #(
    .MAX_DIM(MAX_DIM)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (in_xfer),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .pos_o         (pos)
  );

  assign s_total = s_axis_tdata[15:0];
  assign s_horiz = s_axis_tdata[32:16];
  assign s_diag  = s_axis_tdata[49:33];

  assign coef = coef_lookup(mode_q, pos.row_odd, pos.phase);
  assign ph_d = ProdW'(coef.cos_c) * ProdW'(s_horiz);
  assign pd_d = ProdW'(coef.sin_c) * ProdW'(s_diag);
  assign v1_d = in_xfer || (v1_q && !adv2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      if (adv2) begin
        v2_q <= 1'b1;
      end else if (m_axis_tready) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      total_q <= s_total;
      ph_q    <= ph_d;
      pd_q    <= pd_d;
      last1_q <= pos.frame_last;
    end
    if (adv2) begin
      out_q   <= out_d;
      last2_q <= last1_q;
    end
  end

  // S0 * 2^14 + C*S1 + S*S2, round half up at bit 15
  assign acc = $signed({4'b0000, total_q, 14'b0}) + AccW'(ph_q) + AccW'(pd_q)
             + RoundHalf;

  always_comb begin
    priority if (acc[AccW-1]) out_d = '0;
    else if (acc[AccW-2:31] != '0) out_d = '1;
    else out_d = acc[30:15];
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = last2_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input not ready with stage one empty");

  a_xfer_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> v1_q)
    else $error("accepted pixel lost from stage one");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 |=> m_axis_tvalid)
    else $error("advanced result not presented");

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> ($stable(ph_q) && $stable(pd_q) && $stable(last1_q)))
    else $error("stalled stage one changed");
`endif

endmodule
